// ===== hw/rtl/dam_pkg.sv =====
// Shared types, widths, constants and helper functions of the dihedral angle pipeline.
`timescale 1ns / 1ps
`default_nettype none
package dam_pkg;

   localparam int COORD_W    = 32;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int SHORT_W    = 16;
   localparam int PROD_W     = 2 * SHORT_W;
   localparam int COS_W      = PROD_W + 2;
   localparam int SGNP_W     = SHORT_W + PROD_W;
   localparam int SGN_W      = SGNP_W + 2;
   localparam int SQ_W       = 2 * PROD_W;
   localparam int ROOT_W     = SQ_W / 2;
   localparam int CORD_W     = 36;
   localparam int ANG_W      = 34;
   localparam int OUT_W      = 25;
   localparam int RND_W      = ROOT_W + 1;
   localparam int RND_SHIFT  = 8;
   localparam int SHIFT_MAX  = DIFF_W - SHORT_W;
   localparam int SHIFT_W    = $clog2(SHIFT_MAX + 1);
   localparam int IDX_W      = 5;
   localparam int SQRT_CELLS = ROOT_W;
   localparam int SQRT_TOP   = SQ_W - 2;

   localparam int CORDIC_STAGES = 24;
   localparam int CORDIC_CELLS  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

   // input regs..sum stage, sqrt chain, CORDIC setup, CORDIC chain, output reg
   localparam int FRONT_STAGES = 7;
   localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_CELLS + 1 + CORDIC_CELLS + 1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [SHORT_W-1:0] short_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [COS_W-1:0]   cos_type;
   typedef logic [SQ_W-1:0]           sq_type;
   typedef logic signed [CORD_W-1:0]  cord_type;
   typedef logic signed [ANG_W-1:0]   ang_type;
   typedef logic [IDX_W-1:0]          idx_type;

   // side flags that ride along with an item
   typedef struct packed {
      logic cos_neg;
      logic sgn_pos;
      logic zero;
   } flags_type;

   localparam ang_type DEG90  = 34'sd1509949440;
   localparam ang_type DEG180 = 34'sd3019898880;

   function automatic prod_type mul16(input short_type a, input short_type b);
      return PROD_W'(a) * PROD_W'(b);
   endfunction

   // a*b - c*d, exact on 32 bits for 16-bit operands
   function automatic prod_type cross_term(input short_type a, input short_type b,
                                           input short_type c, input short_type d);
      return mul16(a, b) - mul16(c, d);
   endfunction

   // atan(2^-i) in degrees * 2^24, rounded to nearest
   function automatic ang_type atan_deg(input idx_type i);
      ang_type v;
      case (i)
         5'd0:  v = 34'sd754974720;
         5'd1:  v = 34'sd445687602;
         5'd2:  v = 34'sd235489088;
         5'd3:  v = 34'sd119537938;
         5'd4:  v = 34'sd60000934;
         5'd5:  v = 34'sd30029717;
         5'd6:  v = 34'sd15018523;
         5'd7:  v = 34'sd7509720;
         5'd8:  v = 34'sd3754917;
         5'd9:  v = 34'sd1877466;
         5'd10: v = 34'sd938734;
         5'd11: v = 34'sd469367;
         5'd12: v = 34'sd234684;
         5'd13: v = 34'sd117342;
         5'd14: v = 34'sd58671;
         5'd15: v = 34'sd29335;
         5'd16: v = 34'sd14668;
         5'd17: v = 34'sd7334;
         5'd18: v = 34'sd3667;
         5'd19: v = 34'sd1833;
         5'd20: v = 34'sd917;
         5'd21: v = 34'sd458;
         5'd22: v = 34'sd229;
         5'd23: v = 34'sd115;
         5'd24: v = 34'sd57;
         5'd25: v = 34'sd29;
         5'd26: v = 34'sd14;
         5'd27: v = 34'sd7;
         5'd28: v = 34'sd4;
         5'd29: v = 34'sd2;
         5'd30: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dam_squeeze.sv =====
// Vector normalizer: common arithmetic right shift of three components down to 16 bits.
`timescale 1ns / 1ps
`default_nettype none
module dam_squeeze import dam_pkg::*; (
   input  logic      clock,
   input  diff_type  vec_in  [3],
   output short_type vec_out [3]
);

   short_type             vec_ff [3];
   short_type             vec_in_n [3];
   logic [SHIFT_W-1:0]    sel;
   logic                  fit;
   diff_type              hi;

   // smallest shift that brings all three components into 16 bits
   always_comb begin
      sel = SHIFT_W'(SHIFT_MAX);
      fit = 1'b1;
      hi  = '0;
      for (int s = SHIFT_MAX; s >= 0; s--) begin
         fit = 1'b1;
         for (int c = 0; c < 3; c++) begin
            hi = vec_in[c] >>> (SHORT_W - 1 + s);
            if (hi != '0 && hi != '1) fit = 1'b0;
         end
         if (fit) sel = SHIFT_W'(s);
      end
      for (int c = 0; c < 3; c++) begin
         vec_in_n[c] = SHORT_W'(vec_in[c] >>> sel);
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in_n;
   end

   assign vec_out = vec_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/dam_sqrt_cell.sv =====
// One digit cell of the pipelined 64-bit integer square root.
`timescale 1ns / 1ps
`default_nettype none
module dam_sqrt_cell import dam_pkg::*; (
   input  logic      clock,
   input  idx_type   idx,
   input  sq_type    rem_in,
   input  sq_type    res_in,
   input  flags_type flags_in,
   output sq_type    rem_out,
   output sq_type    res_out,
   output flags_type flags_out
);

   sq_type    rem_ff, rem_in_n;
   sq_type    res_ff, res_in_n;
   flags_type flags_ff;
   sq_type    bit_val;
   sq_type    trial;
   logic [5:0] shamt;

   always_comb begin
      shamt   = 6'(SQRT_TOP) - {idx, 1'b0};
      bit_val = SQ_W'(1) << shamt;
      trial   = res_in + bit_val;
      if (rem_in >= trial) begin
         rem_in_n = rem_in - trial;
         res_in_n = (res_in >> 1) + bit_val;
      end else begin
         rem_in_n = rem_in;
         res_in_n = res_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in_n;
      res_ff   <= res_in_n;
      flags_ff <= flags_in;
   end

   assign rem_out   = rem_ff;
   assign res_out   = res_ff;
   assign flags_out = flags_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/dam_cordic_cell.sv =====
// One vectoring-mode CORDIC rotation cell with degree accumulator.
`timescale 1ns / 1ps
`default_nettype none
module dam_cordic_cell import dam_pkg::*; (
   input  logic      clock,
   input  idx_type   idx,
   input  cord_type  x_in,
   input  cord_type  y_in,
   input  ang_type   z_in,
   input  flags_type flags_in,
   output cord_type  x_out,
   output cord_type  y_out,
   output ang_type   z_out,
   output flags_type flags_out
);

   cord_type  x_ff, x_in_n;
   cord_type  y_ff, y_in_n;
   ang_type   z_ff, z_in_n;
   flags_type flags_ff;
   cord_type  xs, ys;

   always_comb begin
      xs = x_in >>> idx;
      ys = y_in >>> idx;
      if (!y_in[CORD_W-1] && (y_in != '0)) begin
         x_in_n = x_in + ys;
         y_in_n = y_in - xs;
         z_in_n = z_in + atan_deg(idx);
      end else begin
         x_in_n = x_in - ys;
         y_in_n = y_in + xs;
         z_in_n = z_in - atan_deg(idx);
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in_n;
      y_ff     <= y_in_n;
      z_ff     <= z_in_n;
      flags_ff <= flags_in;
   end

   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign flags_out = flags_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/dihedral_angle_measure.sv =====
// Top level: fully pipelined signed dihedral angle of four 3D points.
`timescale 1ns / 1ps
`default_nettype none
// Takes one item (points A, B, C, D in signed Q15.16) on every clock with
// start high; busy is high only during reset. Each item yields exactly one
// result, rsp_torsion_deg in signed Q8.16 degrees (-180..180), shown with a
// one-cycle rsp_valid strobe once it has passed all PIPE_DEPTH pipeline
// stages, among them 24 CORDIC stages. The receiver cannot stall: a result
// is there for that one cycle only. The depth is set mostly by the 32-cell
// square root chain and the CORDIC chain, each cell registered; items stream
// through back to back with no gaps.
module dihedral_angle_measure import dam_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [COORD_W-1:0] req_a_x,
   input  logic signed [COORD_W-1:0] req_a_y,
   input  logic signed [COORD_W-1:0] req_a_z,
   input  logic signed [COORD_W-1:0] req_b_x,
   input  logic signed [COORD_W-1:0] req_b_y,
   input  logic signed [COORD_W-1:0] req_b_z,
   input  logic signed [COORD_W-1:0] req_c_x,
   input  logic signed [COORD_W-1:0] req_c_y,
   input  logic signed [COORD_W-1:0] req_c_z,
   input  logic signed [COORD_W-1:0] req_d_x,
   input  logic signed [COORD_W-1:0] req_d_y,
   input  logic signed [COORD_W-1:0] req_d_z,
   output logic                     rsp_valid,
   output logic signed [OUT_W-1:0]  rsp_torsion_deg
);

   // ---------------- item tracking ----------------
   logic                  accept;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;

   assign busy   = reset;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- stage 1: edge vectors ----------------
   coord_type pa [3], pb [3], pc [3], pd [3];
   diff_type  ba1_ff [3], bc1_ff [3], bd1_ff [3];

   assign pa[0] = req_a_x;  assign pa[1] = req_a_y;  assign pa[2] = req_a_z;
   assign pb[0] = req_b_x;  assign pb[1] = req_b_y;  assign pb[2] = req_b_z;
   assign pc[0] = req_c_x;  assign pc[1] = req_c_y;  assign pc[2] = req_c_z;
   assign pd[0] = req_d_x;  assign pd[1] = req_d_y;  assign pd[2] = req_d_z;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         ba1_ff[i] <= DIFF_W'(pa[i]) - DIFF_W'(pb[i]);
         bc1_ff[i] <= DIFF_W'(pb[i]) - DIFF_W'(pc[i]);
         bd1_ff[i] <= DIFF_W'(pd[i]) - DIFF_W'(pb[i]);
      end
   end

   // ---------------- stage 2: scale to 16 bits ----------------
   short_type ba2 [3], bc2 [3], bd2 [3];

   dam_squeeze u_sq_ba (.clock(clock), .vec_in(ba1_ff), .vec_out(ba2));
   dam_squeeze u_sq_bc (.clock(clock), .vec_in(bc1_ff), .vec_out(bc2));
   dam_squeeze u_sq_bd (.clock(clock), .vec_in(bd1_ff), .vec_out(bd2));

   // ---------------- stage 3: plane normals ----------------
   prod_type  n1_3_ff [3], n2_3_ff [3];
   short_type bc3_ff [3];
   diff_type  n1w [3], n2w [3];

   always_ff @(posedge clock) begin
      n1_3_ff[0] <= cross_term(bc2[1], ba2[2], bc2[2], ba2[1]);
      n1_3_ff[1] <= cross_term(bc2[2], ba2[0], bc2[0], ba2[2]);
      n1_3_ff[2] <= cross_term(bc2[0], ba2[1], bc2[1], ba2[0]);
      n2_3_ff[0] <= cross_term(bc2[1], bd2[2], bc2[2], bd2[1]);
      n2_3_ff[1] <= cross_term(bc2[2], bd2[0], bc2[0], bd2[2]);
      n2_3_ff[2] <= cross_term(bc2[0], bd2[1], bc2[1], bd2[0]);
      bc3_ff     <= bc2;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n1w[i] = DIFF_W'(n1_3_ff[i]);
         n2w[i] = DIFF_W'(n2_3_ff[i]);
      end
   end

   // ---------------- stage 4: scale normals ----------------
   short_type n1s [3], n2s [3];
   short_type bc4_ff [3];

   dam_squeeze u_sq_n1 (.clock(clock), .vec_in(n1w), .vec_out(n1s));
   dam_squeeze u_sq_n2 (.clock(clock), .vec_in(n2w), .vec_out(n2s));

   always_ff @(posedge clock) begin
      bc4_ff <= bc3_ff;
   end

   // ---------------- stage 5: m = n2 x n1, cosine term ----------------
   prod_type  m5_ff [3];
   cos_type   cos5_ff;
   short_type bc5_ff [3];

   always_ff @(posedge clock) begin
      m5_ff[0] <= cross_term(n2s[1], n1s[2], n2s[2], n1s[1]);
      m5_ff[1] <= cross_term(n2s[2], n1s[0], n2s[0], n1s[2]);
      m5_ff[2] <= cross_term(n2s[0], n1s[1], n2s[1], n1s[0]);
      cos5_ff  <= COS_W'(mul16(n2s[0], n1s[0])) + COS_W'(mul16(n2s[1], n1s[1]))
                + COS_W'(mul16(n2s[2], n1s[2]));
      bc5_ff   <= bc4_ff;
   end

   // ---------------- stage 6: squares and sign products ----------------
   sq_type                    sqp6_ff [3];
   logic signed [SGNP_W-1:0]  sgp6_ff [3];
   cos_type                   cos6_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sqp6_ff[i] <= SQ_W'(m5_ff[i]) * SQ_W'(m5_ff[i]);
         sgp6_ff[i] <= SGNP_W'(bc5_ff[i]) * SGNP_W'(m5_ff[i]);
      end
      cos6_ff <= cos5_ff;
   end

   // ---------------- stage 7: |m|^2, orientation sign ----------------
   sq_type                   sq7_ff;
   cos_type                  cos7_ff;
   flags_type                fl7_ff, fl7_in;
   logic signed [SGN_W-1:0]  sgn_sum;

   always_comb begin
      sgn_sum        = SGN_W'(sgp6_ff[0]) + SGN_W'(sgp6_ff[1]) + SGN_W'(sgp6_ff[2]);
      fl7_in.cos_neg = cos6_ff[COS_W-1];
      fl7_in.sgn_pos = !sgn_sum[SGN_W-1] && (sgn_sum != '0);
      fl7_in.zero    = 1'b0;
   end

   always_ff @(posedge clock) begin
      sq7_ff  <= sqp6_ff[0] + sqp6_ff[1] + sqp6_ff[2];
      cos7_ff <= cos6_ff;
      fl7_ff  <= fl7_in;
   end

   // ---------------- square root chain, one result bit per cell ----------------
   sq_type    sr_rem [SQRT_CELLS+1];
   sq_type    sr_res [SQRT_CELLS+1];
   flags_type sr_fl  [SQRT_CELLS+1];
   cos_type   cos_dl_ff [SQRT_CELLS];

   assign sr_rem[0] = sq7_ff;
   assign sr_res[0] = '0;
   assign sr_fl[0]  = fl7_ff;

   for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
      dam_sqrt_cell u_cell (
         .clock    (clock),
         .idx      (IDX_W'(g)),
         .rem_in   (sr_rem[g]),
         .res_in   (sr_res[g]),
         .flags_in (sr_fl[g]),
         .rem_out  (sr_rem[g+1]),
         .res_out  (sr_res[g+1]),
         .flags_out(sr_fl[g+1])
      );
   end

   // cosine rides alongside the root cells
   always_ff @(posedge clock) begin
      cos_dl_ff[0] <= cos7_ff;
      for (int i = 1; i < SQRT_CELLS; i++) begin
         cos_dl_ff[i] <= cos_dl_ff[i-1];
      end
   end

   // ---------------- CORDIC setup: fold into the first quadrant ----------------
   logic [ROOT_W-1:0] root;
   cord_type          x_pre_in, y_pre_in;
   ang_type           z_pre_in;
   flags_type         fl_pre_in;
   cord_type          x_pre_ff, y_pre_ff;
   ang_type           z_pre_ff;
   flags_type         fl_pre_ff;

   always_comb begin
      root           = sr_res[SQRT_CELLS][ROOT_W-1:0];
      fl_pre_in      = sr_fl[SQRT_CELLS];
      fl_pre_in.zero = (root == '0);
      if (fl_pre_in.cos_neg) begin
         // obtuse: turn by 90 degrees first
         x_pre_in = CORD_W'(root);
         y_pre_in = -CORD_W'(cos_dl_ff[SQRT_CELLS-1]);
         z_pre_in = DEG90;
      end else begin
         x_pre_in = CORD_W'(cos_dl_ff[SQRT_CELLS-1]);
         y_pre_in = CORD_W'(root);
         z_pre_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      x_pre_ff  <= x_pre_in;
      y_pre_ff  <= y_pre_in;
      z_pre_ff  <= z_pre_in;
      fl_pre_ff <= fl_pre_in;
   end

   // ---------------- CORDIC chain ----------------
   cord_type  cx  [CORDIC_CELLS+1];
   cord_type  cy  [CORDIC_CELLS+1];
   ang_type   cz  [CORDIC_CELLS+1];
   flags_type cfl [CORDIC_CELLS+1];

   assign cx[0]  = x_pre_ff;
   assign cy[0]  = y_pre_ff;
   assign cz[0]  = z_pre_ff;
   assign cfl[0] = fl_pre_ff;

   for (genvar g = 0; g < CORDIC_CELLS; g++) begin : g_cordic
      dam_cordic_cell u_cell (
         .clock    (clock),
         .idx      (IDX_W'(g)),
         .x_in     (cx[g]),
         .y_in     (cy[g]),
         .z_in     (cz[g]),
         .flags_in (cfl[g]),
         .x_out    (cx[g+1]),
         .y_out    (cy[g+1]),
         .z_out    (cz[g+1]),
         .flags_out(cfl[g+1])
      );
   end

   // ---------------- output: clamp, round to Q8.16, apply sign ----------------
   ang_type                 z_end, z_sel;
   flags_type               fl_end;
   logic [RND_W-1:0]        rnd;
   logic [OUT_W-1:0]        mag;
   logic signed [OUT_W-1:0] rsp_deg_ff, rsp_deg_in;

   always_comb begin
      z_end  = cz[CORDIC_CELLS];
      fl_end = cfl[CORDIC_CELLS];
      if (fl_end.zero) begin
         // zero sine: flat angle decided by the cosine sign alone
         z_sel = fl_end.cos_neg ? DEG180 : '0;
      end else if (z_end[ANG_W-1]) begin
         z_sel = '0;
      end else if (z_end > DEG180) begin
         z_sel = DEG180;
      end else begin
         z_sel = z_end;
      end
      rnd        = RND_W'(z_sel[ROOT_W-1:0]) + RND_W'(1 << (RND_SHIFT - 1));
      mag        = rnd[RND_W-1:RND_SHIFT];
      rsp_deg_in = fl_end.sgn_pos ? OUT_W'(mag) : -OUT_W'(mag);
   end

   always_ff @(posedge clock) begin
      rsp_deg_ff <= rsp_deg_in;
   end

   assign rsp_valid       = vld_ff[PIPE_DEPTH-1];
   assign rsp_torsion_deg = rsp_deg_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/dam_checker.sv =====
// Port-level checker for the dihedral angle block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dam_checker import dam_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic signed [COORD_W-1:0] req_a_x,
   input logic signed [COORD_W-1:0] req_a_y,
   input logic signed [COORD_W-1:0] req_a_z,
   input logic signed [COORD_W-1:0] req_b_x,
   input logic signed [COORD_W-1:0] req_b_y,
   input logic signed [COORD_W-1:0] req_b_z,
   input logic signed [COORD_W-1:0] req_c_x,
   input logic signed [COORD_W-1:0] req_c_y,
   input logic signed [COORD_W-1:0] req_c_z,
   input logic signed [COORD_W-1:0] req_d_x,
   input logic signed [COORD_W-1:0] req_d_y,
   input logic signed [COORD_W-1:0] req_d_z,
   input logic                      rsp_valid,
   input logic signed [OUT_W-1:0]   rsp_torsion_deg
);

   localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

   logic [CNT_W-1:0] since_ff, since_in;
   logic             warm;
   logic             acc;
   logic             a_eq_b;

   assign warm     = (since_ff == CNT_W'(PIPE_DEPTH));
   assign since_in = warm ? since_ff : since_ff + CNT_W'(1);
   assign acc      = start && !busy;
   assign a_eq_b   = (req_a_x == req_b_x) && (req_a_y == req_b_y) && (req_a_z == req_b_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         since_ff <= '0;
      end else begin
         since_ff <= since_in;
      end
   end

   // every item comes out exactly once, checked once the pipeline has filled
   a_latency: assert property (@(posedge clock) disable iff (reset)
      warm |-> (rsp_valid == $past(acc, PIPE_DEPTH)))
      else $error("result strobe does not match accepted item");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_torsion_deg >= -25'sd11796480) && (rsp_torsion_deg <= 25'sd11796480))
      else $error("angle outside -180..180");

   // A on top of B means no first plane: the angle is zero
   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      (warm && rsp_valid && $past(acc && a_eq_b, PIPE_DEPTH)) |-> (rsp_torsion_deg == '0))
      else $error("degenerate item gave nonzero angle");

   a_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

bind dihedral_angle_measure dam_checker u_dam_checker (.*);
`default_nettype wire
